// ===== src/cs_pkg.sv =====
// Shared widths, types and constants for the cosine similarity match block.
package cs_pkg;

    localparam int ElemWidth  = 16;
    localparam int AccWidth   = 48;
    localparam int HalfWidth  = AccWidth / 2;
    localparam int WideWidth  = 128;
    localparam int SimWidth   = 16;
    localparam int QuotBits   = 16;
    localparam int PrdWidth   = 32;
    localparam int AddrWidth  = 3;
    localparam int RootScale  = 30;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [AddrWidth-1:0] ADDR_THRESHOLD = 3'd0;
    localparam logic signed [SimWidth-1:0] THRESHOLD_RESET = 16'sd16384;

    typedef struct packed {
        logic signed [AccWidth-1:0] dot;
        logic [AccWidth-1:0]        ref_norm;
        logic [AccWidth-1:0]        qry_norm;
    } vec_sums_t;

    typedef struct packed {
        logic signed [SimWidth-1:0] similarity;
        logic                       matched;
        logic                       zero_norm;
    } sim_result_t;

endpackage

// ===== src/cs_front.sv =====
// Front end: accumulates the dot product and both norms, hands finished sums on.
module cs_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic signed [cs_pkg::ElemWidth-1:0] lhs_value,
    input  logic signed [cs_pkg::ElemWidth-1:0] rhs_value,
    input  logic                               last,
    output logic                               sums_push,
    output cs_pkg::vec_sums_t                  sums
);
    import cs_pkg::*;

    logic signed [AccWidth-1:0] dot_reg, dot_next;
    logic [AccWidth-1:0]        ref_reg, ref_next;
    logic [AccWidth-1:0]        qry_reg, qry_next;
    logic signed [PrdWidth-1:0] prod_ab;
    logic [PrdWidth-1:0]        prod_aa;
    logic [PrdWidth-1:0]        prod_bb;
    logic signed [AccWidth:0]   dot_sum;
    logic [AccWidth:0]          ref_sum;
    logic [AccWidth:0]          qry_sum;

    always_comb
    begin
        prod_ab = lhs_value * rhs_value;
        prod_aa = PrdWidth'(lhs_value * lhs_value);
        prod_bb = PrdWidth'(rhs_value * rhs_value);
        dot_sum = {dot_reg[AccWidth-1], dot_reg} + (AccWidth+1)'(prod_ab);
        ref_sum = {1'b0, ref_reg} + (AccWidth+1)'(prod_aa);
        qry_sum = {1'b0, qry_reg} + (AccWidth+1)'(prod_bb);
        if (dot_sum[AccWidth] != dot_sum[AccWidth-1])
        begin
            dot_next = {dot_sum[AccWidth], {(AccWidth-1){~dot_sum[AccWidth]}}};
        end
        else
        begin
            dot_next = dot_sum[AccWidth-1:0];
        end
        ref_next = ref_sum[AccWidth] ? {AccWidth{1'b1}} : ref_sum[AccWidth-1:0];
        qry_next = qry_sum[AccWidth] ? {AccWidth{1'b1}} : qry_sum[AccWidth-1:0];
        sums.dot      = dot_next;
        sums.ref_norm = ref_next;
        sums.qry_norm = qry_next;
        sums_push     = take && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            ref_reg <= '0;
            qry_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                dot_reg <= '0;
                ref_reg <= '0;
                qry_reg <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                ref_reg <= ref_next;
                qry_reg <= qry_next;
            end
        end
    end

endmodule

// ===== src/cs_queue.sv =====
// Short queue of finished vector sums between the front and back ends.
module cs_queue #(
    parameter int DEPTH = cs_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cs_pkg::vec_sums_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output cs_pkg::vec_sums_t pop_data
);
    import cs_pkg::*;

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    vec_sums_t             mem [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [CntWidth-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == CntWidth'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CntWidth'(do_push) - CntWidth'(do_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntWidth'(DEPTH))
        else $error("Queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!not_empty && !push) |=> !not_empty)
        else $error("Queue filled without a push.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("Full queue drained without a pop.");

endmodule

// ===== src/cs_back.sv =====
// Back end: multiplies out the norm product and squared dot, finds the quotient bit by bit.
module cs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sums_ready,
    input  cs_pkg::vec_sums_t                 sums,
    output logic                              sums_pop,
    input  logic signed [cs_pkg::SimWidth-1:0] threshold,
    output logic                              res_valid,
    output cs_pkg::sim_result_t               res,
    input  logic                              res_pop
);
    import cs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ITER = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t              state_reg;
    logic [3:0]               cnt_reg;
    logic [3:0]               bit_reg;
    logic [AccWidth-1:0]      na_reg;
    logic [AccWidth-1:0]      nb_reg;
    logic [AccWidth-1:0]      mag_reg;
    logic                     neg_reg;
    logic [2*HalfWidth-1:0]   pp_reg;
    logic [WideWidth-1:0]     p_reg;
    logic [WideWidth-1:0]     r_reg;
    logic [WideWidth-1:0]     s_reg;
    logic [WideWidth-1:0]     u_reg;
    logic [WideWidth-1:0]     v_reg;
    logic [QuotBits-1:0]      q_reg;
    logic                     res_valid_reg;
    sim_result_t              res_reg;

    logic [AccWidth-1:0]      op_x;
    logic [AccWidth-1:0]      op_y;
    logic [HalfWidth-1:0]     half_x;
    logic [HalfWidth-1:0]     half_y;
    logic [3:0]               prev_cnt;
    logic [WideWidth-1:0]     pp_shifted;
    logic [WideWidth-1:0]     cand;
    logic                     allowed;
    logic                     zero_norm;
    logic signed [SimWidth:0] sim_wide;

    always_comb
    begin
        op_x     = cnt_reg[2] ? mag_reg : na_reg;
        op_y     = cnt_reg[2] ? mag_reg : nb_reg;
        half_x   = cnt_reg[0] ? op_x[AccWidth-1:HalfWidth] : op_x[HalfWidth-1:0];
        half_y   = cnt_reg[1] ? op_y[AccWidth-1:HalfWidth] : op_y[HalfWidth-1:0];
        prev_cnt = cnt_reg - 4'd1;
        case (prev_cnt[1:0])
            2'd0:    pp_shifted = WideWidth'(pp_reg);
            2'd3:    pp_shifted = WideWidth'(pp_reg) << (2 * HalfWidth);
            default: pp_shifted = WideWidth'(pp_reg) << HalfWidth;
        endcase
        cand    = s_reg + u_reg + v_reg;
        allowed = (bit_reg == 4'd15) ? neg_reg : !q_reg[QuotBits-1];
        zero_norm = (na_reg == '0) || (nb_reg == '0);
        if (zero_norm)
        begin
            sim_wide = '0;
        end
        else if (neg_reg)
        begin
            sim_wide = -$signed({1'b0, q_reg});
        end
        else
        begin
            sim_wide = $signed({1'b0, q_reg});
        end
    end

    assign sums_pop  = (state_reg == ST_IDLE) && sums_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        pp_reg <= half_x * half_y;
        case (state_reg)
            ST_IDLE:
            begin
                na_reg  <= sums.ref_norm;
                nb_reg  <= sums.qry_norm;
                neg_reg <= sums.dot[AccWidth-1];
                mag_reg <= sums.dot[AccWidth-1] ? AccWidth'(-sums.dot) : sums.dot;
                p_reg   <= '0;
                r_reg   <= '0;
            end
            ST_MUL:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (prev_cnt[2])
                    begin
                        r_reg <= r_reg + (pp_shifted << RootScale);
                    end
                    else
                    begin
                        p_reg <= p_reg + pp_shifted;
                    end
                end
                s_reg <= '0;
                u_reg <= '0;
                v_reg <= p_reg << RootScale;
                if (cnt_reg == 4'd5)
                begin
                    v_reg <= (p_reg + pp_shifted) << RootScale;
                end
                q_reg <= '0;
            end
            ST_ITER:
            begin
                v_reg <= v_reg >> 2;
                if (allowed && (cand <= r_reg))
                begin
                    s_reg <= cand;
                    u_reg <= (u_reg >> 1) + v_reg;
                    q_reg <= q_reg | (QuotBits'(1) << bit_reg);
                end
                else
                begin
                    u_reg <= u_reg >> 1;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_reg.similarity <= sim_wide[SimWidth-1:0];
                    res_reg.matched    <= ($signed(sim_wide[SimWidth-1:0]) >= threshold);
                    res_reg.zero_norm  <= zero_norm;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (sums_ready)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8)
                    begin
                        bit_reg   <= 4'd15;
                        state_reg <= ST_ITER;
                    end
                end
                ST_ITER:
                begin
                    bit_reg <= bit_reg - 4'd1;
                    if (bit_reg == 4'd0)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || res_pop)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (s_reg <= r_reg))
        else $error("Accepted square exceeds the scaled squared dot product.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER && !neg_reg) |-> !q_reg[QuotBits-1])
        else $error("Positive quotient exceeds its cap.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.zero_norm) |-> (res_reg.similarity == '0))
        else $error("Zero-norm result carries a nonzero similarity.");

endmodule

// ===== src/cosine_similarity_match_top.sv =====
// Top level of the cosine similarity match block: ports, threshold register, wiring.
//
//  Channel     Handshake          Payload
//  input       push / full        lhs_value, rhs_value, last
//  result      pop / empty        similarity, matched, zero_norm
//  config      APB psel/penable   paddr, pwdata, prdata (threshold at 0)
//
// One element pair is accepted per cycle while full is low; the final pair of a vector queues its sums.
// The back end works on one vector's sums at a time: the shared 24x24 multiplier builds
// the norm product and squared dot, then the 16 quotient bits are found bit by bit.
// Reset clears the accumulators, the queue and the result valid flag; the threshold resets to 0.5.
// full rises only when the sums queue is full; a held result stalls the back end alone.
module cosine_similarity_match_top #(
    parameter int QUEUE_DEPTH = cs_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [cs_pkg::ElemWidth-1:0] lhs_value,
    input  logic signed [cs_pkg::ElemWidth-1:0] rhs_value,
    input  logic                               last,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [cs_pkg::SimWidth-1:0]  similarity,
    output logic                               matched,
    output logic                               zero_norm,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cs_pkg::AddrWidth-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import cs_pkg::*;

    logic signed [SimWidth-1:0] threshold_reg;
    logic                       take;
    logic                       sums_push;
    vec_sums_t                  sums_in;
    vec_sums_t                  sums_out;
    logic                       sums_ready;
    logic                       sums_pop;
    logic                       res_valid;
    sim_result_t                res;

    assign pready = 1'b1;
    assign take   = push && !full;
    assign prdata = (paddr == ADDR_THRESHOLD) ? {{(32-SimWidth){1'b0}}, threshold_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_THRESHOLD[2]))
        begin
            threshold_reg <= pwdata[SimWidth-1:0];
        end
    end

    cs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .lhs_value (lhs_value),
        .rhs_value (rhs_value),
        .last      (last),
        .sums_push (sums_push),
        .sums      (sums_in)
    );

    cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sums_push),
        .push_data (sums_in),
        .full      (full),
        .pop       (sums_pop),
        .not_empty (sums_ready),
        .pop_data  (sums_out)
    );

    cs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sums_ready (sums_ready),
        .sums       (sums_out),
        .sums_pop   (sums_pop),
        .threshold  (threshold_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop)
    );

    assign empty      = !res_valid;
    assign similarity = res.similarity;
    assign matched    = res.matched;
    assign zero_norm  = res.zero_norm;

endmodule

// ===== test/cosine_similarity_match_top_tb.sv =====
// Testbench for the cosine similarity match block: streamed vectors checked against a local predictor.
`timescale 1ns / 1ps

module cosine_similarity_match_top_tb;

    import cs_pkg::*;

    localparam int DrainCycles = 200;
    localparam int IdleLimit   = 20000;

    localparam logic signed [47:0] DotMax  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] DotMin  = -48'sh7FFF_FFFF_FFFF - 48'sd1;
    localparam logic [47:0]        NormMax = 48'hFFFF_FFFF_FFFF;

    localparam logic [AddrWidth-1:0] UnusedAddr = 3'd4;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic signed [ElemWidth-1:0] lhs_value;
    logic signed [ElemWidth-1:0] rhs_value;
    logic                       last;
    logic                       empty;
    logic                       pop;
    logic signed [SimWidth-1:0] similarity;
    logic                       matched;
    logic                       zero_norm;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [AddrWidth-1:0]       paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    logic signed [SimWidth-1:0] threshold_q;
    logic signed [47:0]         dot_sum;
    logic [47:0]                lhs_norm_sum;
    logic [47:0]                rhs_norm_sum;
    sim_result_t                pending_results[$];

    int  error_count;
    int  result_count;
    int  vector_count;
    int  idle_cycles;
    bit  hold_off;

    cosine_similarity_match_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .lhs_value  (lhs_value),
        .rhs_value  (rhs_value),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .similarity (similarity),
        .matched    (matched),
        .zero_norm  (zero_norm),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Largest q <= cap with q*q*na*nb <= dmag*dmag*2^30.
    function automatic logic [16:0] cosine_magnitude(logic [47:0] dmag, logic [47:0] na,
                                                     logic [47:0] nb, logic [16:0] cap);
        logic [127:0] norm_product;
        logic [127:0] dot_square;
        logic [16:0]  q;
        logic [16:0]  c;
        logic [159:0] lhs;
        norm_product = 128'(na) * 128'(nb);
        dot_square   = (128'(dmag) * 128'(dmag)) << RootScale;
        q = '0;
        for (int b = 15; b >= 0; b--)
        begin
            c = q | (17'd1 << b);
            if (c <= cap)
            begin
                lhs = 160'(norm_product) * 160'(c) * 160'(c);
                if (lhs[127:0] <= dot_square)
                    q = c;
            end
        end
        return q;
    endfunction

    task automatic predict_similarity(logic signed [15:0] a, logic signed [15:0] b,
                                      logic is_last);
        logic signed [49:0] dot_next;
        logic [48:0]        norm_next;
        logic signed [31:0] sim;
        logic signed [47:0] neg;
        sim_result_t        res;
        dot_next = 50'(dot_sum) + 50'(32'(a) * 32'(b));
        if (dot_next > 50'(DotMax))
            dot_sum = DotMax;
        else if (dot_next < 50'(DotMin))
            dot_sum = DotMin;
        else
            dot_sum = dot_next[47:0];
        norm_next = 49'(lhs_norm_sum) + 49'(32'(32'(a) * 32'(a)));
        lhs_norm_sum = norm_next[48] ? NormMax : norm_next[47:0];
        norm_next = 49'(rhs_norm_sum) + 49'(32'(32'(b) * 32'(b)));
        rhs_norm_sum = norm_next[48] ? NormMax : norm_next[47:0];
        if (!is_last)
            return;
        res.zero_norm = 1'b0;
        if (lhs_norm_sum == 0 || rhs_norm_sum == 0)
        begin
            sim = 0;
            res.zero_norm = 1'b1;
        end
        else if (dot_sum >= 0)
            sim = 32'(cosine_magnitude(dot_sum, lhs_norm_sum, rhs_norm_sum, 17'd32767));
        else
        begin
            neg = -dot_sum;
            sim = -32'(cosine_magnitude(neg, lhs_norm_sum, rhs_norm_sum, 17'd32768));
        end
        res.similarity = sim[15:0];
        res.matched    = (sim >= 32'(threshold_q));
        pending_results.push_back(res);
        dot_sum = '0;
        lhs_norm_sum = '0;
        rhs_norm_sum = '0;
    endtask

    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic is_last,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        lhs_value <= a;
        rhs_value <= b;
        last      <= is_last;
        do
            @(posedge clk);
        while (full);
        predict_similarity(a, b, is_last);
        if (is_last)
            vector_count++;
    endtask

    task automatic send_vector(int len, int mode);
        logic signed [15:0] a;
        logic signed [15:0] b;
        for (int k = 0; k < len; k++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (mode)
                1: b = a;
                2: b = -a;
                3: b = a + 16'($urandom_range(0, 64)) - 16'sd32;
                4:
                begin
                    a = 16'($urandom_range(0, 8)) - 16'sd4;
                    b = 16'($urandom_range(0, 8)) - 16'sd4;
                end
                default: ;
            endcase
            send_pair(a, b, k == len - 1);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_threshold(logic signed [15:0] value, logic [AddrWidth-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            threshold_q = value;
    endtask

    task automatic test_directed();
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd256, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd256, 1'b1);
        send_pair(16'sd256, 16'sd256, 1'b1);
        send_pair(16'sd256, -16'sd256, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(-16'sh8000, -16'sh8000, 1'b1);
        send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh7FFF, -16'sh8000, 1'b0);
        send_pair(16'sd3, 16'sd5, 1'b1);
        send_pair(16'sd100, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd100, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(-16'sd1, 16'sh5555, 1'b0);
        send_pair(16'shAAAA, -16'sd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_thresholds();
        logic signed [15:0] levels[5] = '{-16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1};
        foreach (levels[i])
        begin
            write_threshold(levels[i], ADDR_THRESHOLD);
            send_pair(16'sd0, 16'sd0, 1'b1);
            send_vector(3, 1);
            send_vector(3, 2);
            send_vector(4, 0);
            wait_drained();
        end
        write_threshold(16'sd123, UnusedAddr);
        send_vector(2, 1);
        wait_drained();
    endtask

    task automatic test_random();
        while (vector_count < 95)
        begin
            if (($urandom_range(0, 9)) == 0)
            begin
                wait_drained();
                write_threshold(16'($urandom), ADDR_THRESHOLD);
            end
            send_vector($urandom_range(1, 6), $urandom_range(0, 4));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int k = 0; k < 12; k++)
            send_pair(16'($urandom), 16'($urandom), 1'b1, 1);
        hold_off = 1'b0;
        wait_drained();
    endtask

    task automatic test_long_vector();
        for (int k = 0; k < 600; k++)
            send_pair(16'sh7FFF, -16'sh8000, k == 599, k > 2);
        wait_drained();
    endtask

    initial
    begin
        push = 1'b0;
        lhs_value = '0;
        rhs_value = '0;
        last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        threshold_q = THRESHOLD_RESET;
        dot_sum = '0;
        lhs_norm_sum = '0;
        rhs_norm_sum = '0;
        error_count = 0;
        result_count = 0;
        vector_count = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_thresholds();
        test_backpressure();
        test_random();
        test_long_vector();
        $display("Covered %0d vectors and %0d result transactions, threshold extremes,",
                 vector_count, result_count);
        $display("zero norms, saturation and a stalled result side.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        sim_result_t want;
        if (rst_n && pop && !empty)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction, similarity %0d", similarity);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (similarity !== want.similarity)
                begin
                    $error("similarity expected %0d actual %0d", want.similarity, similarity);
                    error_count++;
                end
                if (matched !== want.matched)
                begin
                    $error("matched expected %0d actual %0d", want.matched, matched);
                    error_count++;
                end
                if (zero_norm !== want.zero_norm)
                begin
                    $error("zero_norm expected %0d actual %0d", want.zero_norm, zero_norm);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || psel || hold_off || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
